// ===== design/lgge_pkg.sv =====
// Shared constants for the life grid generation engine: grid limits, field widths
// and command codes. No dependencies.
`default_nettype none

package lgge_pkg;

  // Grid limits.
  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 128;

  // Address widths into the grid memory and the counts of rows/columns in use.
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);
  localparam int NR_W   = $clog2(MAX_ROWS + 1);
  localparam int NC_W   = $clog2(MAX_COLS + 1);

  // Fixed widths of the command beat fields and the size registers.
  localparam int CMD_W      = 2;
  localparam int ROW_FW     = 6;
  localparam int COL_FW     = 7;
  localparam int ROW_CNT_W  = 7;
  localparam int COL_CNT_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 16;
  localparam int OUT_TDATA_W = 8;

  // Reset values of the size registers.
  localparam logic [ROW_CNT_W-1:0] ROW_CNT_RST = 7'd64;
  localparam logic [COL_CNT_W-1:0] COL_CNT_RST = 8'd128;

  // Configuration register indexes.
  localparam logic CFG_ROW_COUNT = 1'b0;
  localparam logic CFG_COL_COUNT = 1'b1;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_TOGGLE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ADVANCE = 2'd2;
  localparam logic [CMD_W-1:0] CMD_READ    = 2'd3;

  // Column and row qualifiers handed to the row rule.
  typedef struct packed {
    logic [MAX_COLS-1:0] col_mask;  // one where the column is in use
    logic                next_live; // the row below is in use
  } row_ctl_t;

endpackage

`default_nettype wire

// ===== design/lgge_row_rule.sv =====
// One row of the B3/S23 update: a lane per column counts the eight neighbors.
// Depends on lgge_pkg.
`default_nettype none

module lgge_row_rule (
  input  wire logic [lgge_pkg::MAX_COLS-1:0] prev_i,
  input  wire logic [lgge_pkg::MAX_COLS-1:0] cur_i,
  input  wire logic [lgge_pkg::MAX_COLS-1:0] next_i,
  input  wire lgge_pkg::row_ctl_t            ctl_i,
  output logic      [lgge_pkg::MAX_COLS-1:0] new_o
);

  logic [lgge_pkg::MAX_COLS+1:0] pp, cp, np;

  // Columns beyond the used area and the missing row below read as dead.
  assign pp = {1'b0, prev_i & ctl_i.col_mask, 1'b0};
  assign cp = {1'b0, cur_i & ctl_i.col_mask, 1'b0};
  assign np = ctl_i.next_live ? {1'b0, next_i & ctl_i.col_mask, 1'b0} : '0;

  always_comb begin
    logic [3:0] n;
    new_o = cur_i;
    for (int j = 0; j < lgge_pkg::MAX_COLS; j++) begin
      n = 4'(pp[j]) + 4'(pp[j+1]) + 4'(pp[j+2]) + 4'(cp[j]) + 4'(cp[j+2])
        + 4'(np[j]) + 4'(np[j+1]) + 4'(np[j+2]);
      if (ctl_i.col_mask[j]) begin
        new_o[j] = (n == 4'd3) || ((n == 4'd2) && cur_i[j]);
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/life_grid_generation_engine_top.sv =====
// Top level of the life grid generation engine: command stream in, result stream
// out, grid memory and sequencer. Depends on lgge_pkg and lgge_row_rule.
//
// Usage. Each beat on the slave stream carries one command (toggle a cell, set a
// cell alive, advance one generation, read a cell) with a row and column. Every
// command yields exactly one result beat on the master stream: the addressed
// cell's state after the command and an out-of-range flag. The grid lives in one
// synchronous memory of one row word per entry; a command reads the row, changes
// it and writes it back.
// Sequencing. A toggle, set or read reads its row at acceptance; the row is then
// modified, written back for an in-range toggle or set, and its result beat is
// loaded into the output register. An advance sweeps the rows in use, one row
// word per cycle through the read-compute-write loop around the memory port, then
// reads the addressed row again and reports the addressed cell.
// The next command is accepted as soon as the sequencer is back in idle, even
// while a result beat still waits.
// Reset. rst_ni clears the size registers to 64 by 128, the output beat and a
// valid bit per row; a row whose bit is clear reads as all dead, so no clearing
// pass is needed.
// Stalls. If the receiver holds m_axis_tready low, a finished result stays in the
// output register; a following command runs until its own result is due and then
// waits there, holding off further commands.
// Write size registers via cfg_we_i only when idle; the block does not enforce it.
`default_nettype none

module life_grid_generation_engine_top (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port.
  input  wire logic                                cfg_we_i,
  input  wire logic                                cfg_idx_i,
  input  wire logic [lgge_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // Command stream.
  input  wire logic                                s_axis_tvalid,
  output logic                                     s_axis_tready,
  // Fields from bit 0: cmd[1:0], row[7:2], col[14:8], zero pad[15].
  input  wire logic [lgge_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Result stream.
  output logic                                     m_axis_tvalid,
  input  wire logic                                m_axis_tready,
  // Fields from bit 0: cell_alive[0], out_of_range[1], zero pad[7:2].
  output logic [lgge_pkg::OUT_TDATA_W-1:0]         m_axis_tdata
);

  localparam int ROWS   = lgge_pkg::MAX_ROWS;
  localparam int COLS   = lgge_pkg::MAX_COLS;
  localparam int ROW_AW = lgge_pkg::ROW_AW;
  localparam int COL_AW = lgge_pkg::COL_AW;
  localparam int NR_W   = lgge_pkg::NR_W;
  localparam int NC_W   = lgge_pkg::NC_W;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE       = 3'd0;
  localparam logic [2:0] ST_GEN_LOAD   = 3'd1;
  localparam logic [2:0] ST_GEN_RUN    = 3'd2;
  localparam logic [2:0] ST_CELL_ISSUE = 3'd3;
  localparam logic [2:0] ST_CELL_MOD   = 3'd4;

  // Configuration registers.
  logic [lgge_pkg::ROW_CNT_W-1:0] row_count_q;
  logic [lgge_pkg::COL_CNT_W-1:0] col_count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= lgge_pkg::ROW_CNT_RST;
      col_count_q <= lgge_pkg::COL_CNT_RST;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == lgge_pkg::CFG_ROW_COUNT) begin
        row_count_q <= cfg_data_i[lgge_pkg::ROW_CNT_W-1:0];
      end else begin
        col_count_q <= cfg_data_i[lgge_pkg::COL_CNT_W-1:0];
      end
    end
  end

  // Sizes in use are clipped to the grid.
  logic [NR_W-1:0] used_rows;
  logic [NC_W-1:0] used_cols;
  assign used_rows = (32'(row_count_q) < 32'(ROWS)) ? NR_W'(row_count_q) : NR_W'(ROWS);
  assign used_cols = (32'(col_count_q) < 32'(COLS)) ? NC_W'(col_count_q) : NC_W'(COLS);

  logic [COLS-1:0] col_mask;
  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      col_mask[j] = 32'(j) < 32'(used_cols);
    end
  end

  // Input beat fields.
  logic [lgge_pkg::CMD_W-1:0]  in_cmd;
  logic [lgge_pkg::ROW_FW-1:0] in_row;
  logic [lgge_pkg::COL_FW-1:0] in_col;
  assign in_cmd = s_axis_tdata[1:0];
  assign in_row = s_axis_tdata[7:2];
  assign in_col = s_axis_tdata[14:8];

  // Sequencer and command registers.
  logic [2:0]                  state_q, state_d;
  logic [lgge_pkg::CMD_W-1:0]  cmd_q;
  logic [lgge_pkg::ROW_FW-1:0] row_q;
  logic [lgge_pkg::COL_FW-1:0] col_q;
  logic [ROW_AW-1:0]           gen_row_q, gen_row_d;
  logic [COLS-1:0]             prev_q, prev_d, cur_q, cur_d;

  // Output register.
  logic out_valid_q, out_valid_d;
  logic out_alive_q, out_alive_d;
  logic out_oor_q, out_oor_d;

  // Grid memory, its registered read port and the per-row valid bits.
  logic [COLS-1:0] grid_mem [ROWS];
  logic [COLS-1:0] rd_data_q;
  logic            rd_valid_q;
  logic [ROWS-1:0] row_valid_q;
  logic            rd_en, wr_en;
  logic [ROW_AW-1:0] rd_addr, wr_addr;
  logic [COLS-1:0] wr_data;
  logic [COLS-1:0] rd_row;

  assign rd_row = rd_valid_q ? rd_data_q : '0;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      grid_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= grid_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (wr_en) begin
        row_valid_q[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_valid_q <= row_valid_q[rd_addr];
      end
    end
  end

  // Row update for the generation sweep.
  lgge_pkg::row_ctl_t rule_ctl;
  logic [COLS-1:0]    new_row;
  logic               next_live;

  assign next_live          = (32'(gen_row_q) + 32'd1) < 32'(used_rows);
  assign rule_ctl.col_mask  = col_mask;
  assign rule_ctl.next_live = next_live;

  lgge_row_rule u_row_rule (
    .prev_i (prev_q),
    .cur_i  (cur_q),
    .next_i (rd_row),
    .ctl_i  (rule_ctl),
    .new_o  (new_row)
  );

  // Addressed cell of the held command.
  logic            in_range;
  logic [COL_AW-1:0] col_idx;
  logic            old_bit, new_bit;
  logic            out_free;

  assign in_range = (32'(row_q) < 32'(used_rows)) && (32'(col_q) < 32'(used_cols));
  assign col_idx  = COL_AW'(col_q);
  assign old_bit  = rd_row[col_idx];
  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    new_bit = old_bit;
    unique case (cmd_q)
      lgge_pkg::CMD_TOGGLE:  new_bit = !old_bit;
      lgge_pkg::CMD_SET:     new_bit = 1'b1;
      lgge_pkg::CMD_ADVANCE: new_bit = old_bit;
      lgge_pkg::CMD_READ:    new_bit = old_bit;
      default:               new_bit = old_bit;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  always_comb begin
    state_d     = state_q;
    gen_row_d   = gen_row_q;
    prev_d      = prev_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_alive_d = out_alive_q;
    out_oor_d   = out_oor_q;
    rd_en       = 1'b0;
    rd_addr     = ROW_AW'(row_q);
    wr_en       = 1'b0;
    wr_addr     = gen_row_q;
    wr_data     = new_row;

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          rd_en = 1'b1;
          if ((in_cmd == lgge_pkg::CMD_ADVANCE) && (used_rows != '0)) begin
            // Start the sweep with the top row.
            rd_addr   = '0;
            gen_row_d = '0;
            state_d   = ST_GEN_LOAD;
          end else begin
            rd_addr = ROW_AW'(in_row);
            state_d = ST_CELL_MOD;
          end
        end
      end
      ST_GEN_LOAD: begin
        // The top row has no row above it.
        prev_d  = '0;
        cur_d   = rd_row;
        rd_en   = 1'b1;
        rd_addr = ROW_AW'(32'(gen_row_q) + 32'd1);
        state_d = ST_GEN_RUN;
      end
      ST_GEN_RUN: begin
        // The read data is the old row below; write the new current row and
        // fetch the one after. Read and write addresses never coincide.
        wr_en     = 1'b1;
        prev_d    = cur_q;
        cur_d     = rd_row;
        gen_row_d = ROW_AW'(32'(gen_row_q) + 32'd1);
        if (next_live) begin
          rd_en   = 1'b1;
          rd_addr = ROW_AW'(32'(gen_row_q) + 32'd2);
        end else begin
          state_d = ST_CELL_ISSUE;
        end
      end
      ST_CELL_ISSUE: begin
        rd_en   = 1'b1;
        rd_addr = ROW_AW'(row_q);
        state_d = ST_CELL_MOD;
      end
      ST_CELL_MOD: begin
        if (out_free) begin
          wr_addr = ROW_AW'(row_q);
          wr_data = rd_row;
          wr_data[col_idx] = new_bit;
          wr_en = in_range && ((cmd_q == lgge_pkg::CMD_TOGGLE) ||
                               (cmd_q == lgge_pkg::CMD_SET));
          out_valid_d = 1'b1;
          out_alive_d = in_range && new_bit;
          out_oor_d   = !in_range;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      gen_row_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      gen_row_q   <= gen_row_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      cmd_q <= in_cmd;
      row_q <= in_row;
      col_q <= in_col;
    end
    prev_q      <= prev_d;
    cur_q       <= cur_d;
    out_alive_q <= out_alive_d;
    out_oor_q   <= out_oor_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_oor_q, out_alive_q};

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for life_grid_generation_engine_top: a scoreboard class keeps a
// bit-exact B3/S23 grid and checks every result beat against it.
// Depends on lgge_pkg and the engine RTL only.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lgge_pkg::*;

  // Number of random commands after the directed part.
  localparam int RANDOM_ITEMS = 800;
  // Idle cycles granted after the last result before a size register is touched.
  localparam int SETTLE_CYCLES = 6;
  // Length of the one deliberate receiver hold-off, in clock cycles.
  localparam int LONG_HOLD = 200;

  // Expected content of one result beat.
  typedef struct {
    bit alive;
    bit out_of_range;
  } cell_report_t;

  // The scoreboard owns a private copy of the grid and of the two size registers.
  // Every accepted command updates that copy and queues the report the engine owes.
  class life_scoreboard;
    bit [MAX_COLS-1:0] grid [MAX_ROWS];
    bit [ROW_CNT_W-1:0] row_count;
    bit [COL_CNT_W-1:0] col_count;
    cell_report_t report_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned oor_count;
    int unsigned cmd_count [4];

    function new();
      foreach (grid[i]) grid[i] = '0;
      row_count = ROW_CNT_RST;
      col_count = COL_CNT_RST;
    endfunction

    function int rows_in_use();
      return (row_count < MAX_ROWS) ? int'(row_count) : MAX_ROWS;
    endfunction

    function int cols_in_use();
      return (col_count < MAX_COLS) ? int'(col_count) : MAX_COLS;
    endfunction

    function void write_size(logic idx, logic [CFG_DATA_W-1:0] data);
      if (idx == CFG_ROW_COUNT) row_count = data[ROW_CNT_W-1:0];
      else col_count = data[COL_CNT_W-1:0];
    endfunction

    // One generation over the area in use; everything outside it is dead to the
    // neighbour count and keeps its contents.
    function void next_generation();
      bit [MAX_COLS-1:0] prior [MAX_ROWS];
      int nr;
      int nc;
      int live;
      nr = rows_in_use();
      nc = cols_in_use();
      prior = grid;
      for (int i = 0; i < nr; i++) begin
        for (int j = 0; j < nc; j++) begin
          live = 0;
          for (int di = -1; di <= 1; di++) begin
            for (int dj = -1; dj <= 1; dj++) begin
              if ((di != 0 || dj != 0) && i + di >= 0 && i + di < nr &&
                  j + dj >= 0 && j + dj < nc)
                live += prior[i+di][j+dj];
            end
          end
          grid[i][j] = (live == 3) || (live == 2 && prior[i][j]);
        end
      end
    endfunction

    function void note_command(logic [CMD_W-1:0] cmd, logic [ROW_FW-1:0] row,
                               logic [COL_FW-1:0] col);
      cell_report_t rep;
      bit in_area;
      in_area = (row < rows_in_use()) && (col < cols_in_use());
      if (cmd == CMD_ADVANCE) next_generation();
      if (in_area && cmd == CMD_TOGGLE) grid[row][col] = ~grid[row][col];
      else if (in_area && cmd == CMD_SET) grid[row][col] = 1'b1;
      rep.alive = in_area ? grid[row][col] : 1'b0;
      rep.out_of_range = !in_area;
      report_q.push_back(rep);
      cmd_count[cmd]++;
      if (!in_area) oor_count++;
    endfunction

    function void check_report(logic [OUT_TDATA_W-1:0] beat);
      cell_report_t rep;
      if (report_q.size() == 0) begin
        $error("result beat with no command outstanding: tdata=%h", beat);
        errors++;
        return;
      end
      rep = report_q.pop_front();
      checked++;
      if (beat[0] !== rep.alive) begin
        $error("cell_alive mismatch: expected %0b, actual %0b", rep.alive, beat[0]);
        errors++;
      end
      if (beat[1] !== rep.out_of_range) begin
        $error("out_of_range mismatch: expected %0b, actual %0b", rep.out_of_range, beat[1]);
        errors++;
      end
    endfunction

    function int pending();
      return report_q.size();
    endfunction
  endclass

  // Every input has a known value from time zero.
  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic cfg_idx_i = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  // Fields from bit 0: cmd[1:0], row[7:2], col[14:8], zero pad[15].
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  // Fields from bit 0: cell_alive[0], out_of_range[1], zero pad[7:2].
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  life_scoreboard sb = new();

  // When set, neither side inserts idle cycles, so the engine sees back-to-back beats.
  bit quiet = 1'b0;
  // Raised by the stimulus to ask the result sink for one long hold-off.
  bit hold_off_req = 1'b0;
  int unsigned long_holds = 0;
  int unsigned size_settings = 0;

  always #5ns clk_i = ~clk_i;

  life_grid_generation_engine_top i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // Offers one command beat. Called at a falling edge and returns at the falling edge
  // after the beat was taken, with tvalid still high so a following beat can go
  // back-to-back without lowering it. The prediction is made at the accepting edge.
  task automatic send(logic [CMD_W-1:0] cmd, logic [ROW_FW-1:0] row, logic [COL_FW-1:0] col);
    int gap;
    int k;
    k = $urandom_range(0, 19);
    if (quiet || k < 12) gap = 0;
    else if (k < 18) gap = $urandom_range(1, 3);
    else gap = $urandom_range(10, 30);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {1'b0, col, row, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, row, col);
    @(negedge clk_i);
  endtask

  // Stops offering beats and waits until every owed result has arrived, then lets the
  // engine's pipeline run dry so a size register may be written safely.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Writes row count, then column count, on consecutive edges; the engine must be idle.
  task automatic program_sizes(logic [CFG_DATA_W-1:0] rows_data,
                               logic [CFG_DATA_W-1:0] cols_data);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_ROW_COUNT;
    cfg_data_i <= rows_data;
    @(negedge clk_i);
    sb.write_size(CFG_ROW_COUNT, rows_data);
    cfg_idx_i <= CFG_COL_COUNT;
    cfg_data_i <= cols_data;
    @(negedge clk_i);
    sb.write_size(CFG_COL_COUNT, cols_data);
    cfg_we_i <= 1'b0;
    size_settings++;
  endtask

  // Result sink. A beat is checked at the rising edge where tvalid and tready are both
  // high; tready is then redecided at the falling edge. Ready and stall runs have
  // random lengths, mostly short with the odd long stall, and on request one long
  // hold-off counted here in cycles so that the engine backs up into its input.
  initial begin : result_sink
    int run_left;
    int k;
    run_left = 0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) sb.check_report(m_axis_tdata);
      @(negedge clk_i);
      if (run_left > 0) begin
        run_left--;
      end else if (hold_off_req) begin
        hold_off_req = 1'b0;
        m_axis_tready <= 1'b0;
        run_left = LONG_HOLD;
        long_holds++;
      end else if (quiet) begin
        m_axis_tready <= 1'b1;
      end else begin
        k = $urandom_range(0, 19);
        if (k < 11) begin
          m_axis_tready <= 1'b1;
          run_left = $urandom_range(0, 15);
        end else if (k < 18) begin
          m_axis_tready <= 1'b0;
          run_left = $urandom_range(0, 2);
        end else begin
          m_axis_tready <= 1'b0;
          run_left = $urandom_range(10, 40);
        end
      end
    end
  end

  // Main stimulus: reset, a directed pass through the corner cases, then random phases
  // each under its own pair of sizes, and finally the verdict.
  initial begin : stimulus
    int phase;
    int n_items;
    int n_random;
    int k;
    int nr;
    int nc;
    logic [CMD_W-1:0] cmd;
    logic [ROW_FW-1:0] row;
    logic [COL_FW-1:0] col;
    logic [CFG_DATA_W-1:0] rows_data;
    logic [CFG_DATA_W-1:0] cols_data;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Full 64 x 128 grid after reset. Toggle both ways, then build an L of three cells
    // in the far corner so that the empty fourth corner cell is born. Setting a live
    // cell keeps it alive, and the opposite edge must not see the corner (no wrap).
    send(CMD_TOGGLE, 0, 0);
    send(CMD_READ, 0, 0);
    send(CMD_TOGGLE, 0, 0);
    send(CMD_SET, 63, 127);
    send(CMD_SET, 63, 126);
    send(CMD_SET, 62, 127);
    send(CMD_SET, 63, 126);
    send(CMD_ADVANCE, 62, 126);
    send(CMD_READ, 63, 0);
    settle();

    // Smallest useful grid, 3 x 3, with the unused top bit of the row data set. A
    // horizontal blinker turns vertical; addresses past the sizes are flagged, and an
    // advance with such an address still runs the generation. The corner cells
    // written above now lie outside the area and must be left alone.
    program_sizes(8'h83, 8'd3);
    send(CMD_SET, 1, 0);
    send(CMD_SET, 1, 1);
    send(CMD_SET, 1, 2);
    send(CMD_ADVANCE, 0, 1);
    send(CMD_TOGGLE, 5, 5);
    send(CMD_ADVANCE, 3, 0);
    send(CMD_READ, 63, 127);
    settle();

    // No rows in use: every address is out of range and nothing changes.
    program_sizes(8'd0, 8'd128);
    send(CMD_ADVANCE, 0, 0);
    send(CMD_SET, 0, 0);
    settle();

    // Register values beyond the grid limits clamp to the full grid.
    program_sizes(8'd127, 8'd255);
    send(CMD_READ, 63, 127);
    send(CMD_READ, 2, 1);
    send(CMD_ADVANCE, 63, 63);
    settle();

    // A single cell has no neighbours and dies on the next generation.
    program_sizes(8'd1, 8'd1);
    send(CMD_SET, 0, 0);
    send(CMD_ADVANCE, 0, 0);
    send(CMD_READ, 0, 0);
    settle();

    // Random phases. Sizes lean toward small grids so patterns stay dense and evolve,
    // with the extremes, zero and oversized values mixed in. Most addresses fall
    // inside the area in use; the rest span the whole field range.
    n_random = 0;
    phase = 0;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(0, 11))
        0:       rows_data = 8'd0;
        1:       rows_data = 8'd1;
        2:       rows_data = 8'd127;
        3:       rows_data = 8'(MAX_ROWS);
        4:       rows_data = 8'($urandom_range(MAX_ROWS + 1, 127));
        default: rows_data = 8'($urandom_range(2, 16));
      endcase
      rows_data[7] = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 11))
        0:       cols_data = 8'd0;
        1:       cols_data = 8'd1;
        2:       cols_data = 8'd255;
        3:       cols_data = 8'(MAX_COLS);
        4:       cols_data = 8'($urandom_range(MAX_COLS + 1, 255));
        default: cols_data = 8'($urandom_range(2, 24));
      endcase
      program_sizes(rows_data, cols_data);
      nr = sb.rows_in_use();
      nc = sb.cols_in_use();

      // Phase 2 runs without gaps and asks the sink for its long hold-off, so the
      // engine fills up and must stall the command stream.
      quiet = (phase == 2) || ($urandom_range(0, 4) == 0);
      if (phase == 2) hold_off_req = 1'b1;

      n_items = $urandom_range(20, 60);
      for (int i = 0; i < n_items; i++) begin
        k = $urandom_range(0, 99);
        if (k < 30) cmd = CMD_TOGGLE;
        else if (k < 55) cmd = CMD_SET;
        else if (k < 75) cmd = CMD_READ;
        else cmd = CMD_ADVANCE;
        if (nr > 0 && nc > 0 && $urandom_range(0, 9) < 8) begin
          row = ROW_FW'($urandom_range(0, nr - 1));
          col = COL_FW'($urandom_range(0, nc - 1));
        end else begin
          row = ROW_FW'($urandom_range(0, MAX_ROWS - 1));
          col = COL_FW'($urandom_range(0, MAX_COLS - 1));
        end
        send(cmd, row, col);
        // Now and then the sender waits for every result before going on.
        if ($urandom_range(0, 49) == 0) settle();
      end
      n_random += n_items;
      settle();
      phase++;
    end

    quiet = 1'b0;
    repeat (10) @(negedge clk_i);

    $display("Run covered %0d commands: toggle %0d, set %0d, advance %0d, read %0d.",
             sb.checked, sb.cmd_count[CMD_TOGGLE], sb.cmd_count[CMD_SET],
             sb.cmd_count[CMD_ADVANCE], sb.cmd_count[CMD_READ]);
    $display("%0d out of range, %0d size settings, %0d long hold-offs, %0d mismatches.",
             sb.oor_count, size_settings, long_holds, sb.errors);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (full-grid advances, long stalls and
  // gaps on every beat), so only a hang ends up here.
  initial begin : watchdog
    #20_000_000;
    $display("Timeout with %0d results still outstanding.", sb.pending());
    $display("DONE: errors detected");
    $finish;
  end

endmodule
